### hw/rtl/bsa_pkg.sv
// bsa_pkg: shared constants, codes and types for the block slot allocator
// no dependencies; used by every other file of the block except bsa_ram
package bsa_pkg;

   localparam int MAX_BLOCKS      = 8;
   localparam int SLOTS_PER_BLOCK = 64;
   localparam int BLK_W           = $clog2(MAX_BLOCKS);
   localparam int SLOT_W          = $clog2(SLOTS_PER_BLOCK);
   localparam int ADDR_W          = BLK_W + SLOT_W;
   localparam int CNT_W           = SLOT_W + 1;
   localparam int ACT_W           = BLK_W + 1;
   localparam int TOT_W           = ADDR_W + 1;
   localparam int HOLE_W          = SLOT_W + 1;
   localparam int RAM_DEPTH       = MAX_BLOCKS * SLOTS_PER_BLOCK;
   localparam int STAT_W          = 2;
   localparam int EPB_W           = 7;

   localparam logic OPC_ALLOC = 1'b0;
   localparam logic OPC_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_ALLOC   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FREED   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OOM     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd3;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_OOM, OP_IGNORE, OP_ACTIVATE, OP_BLK_DEC, OP_BUMP,
      OP_RD_LAST, OP_TAKE, OP_END_DEC, OP_SCAN_INIT, OP_RD_IDX, OP_IDX_INC,
      OP_TOP0, OP_PURGE_INIT, OP_PURGE_HIT, OP_PURGE_LAST, OP_PURGE_END,
      OP_CMP_INIT, OP_CMP_STEP, OP_CMP_END, OP_APPEND, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic total_zero;
      logic active_full;
      logic has_free;
      logic blk_zero;
      logic end_zero;
      logic end_full;
      logic scan_done;
      logic free_bad;
      logic is_top;
      logic slot_zero;
      logic hit;
      logic rd_zero;
   } dp_sts_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SEARCH, S_TAKE, S_TRIM_RD, S_TRIM_CK, S_FIND_RD,
      S_FIND_CK, S_PURGE_RD, S_PURGE_CK, S_CMP_RD, S_CMP_CK, S_APPEND, S_OUT
   } ctrl_state_type;

endpackage

### hw/rtl/bsa_req_if.sv
// bsa_req_if: request channel, valid/ready with opcode and slot address
// depends on bsa_pkg
interface bsa_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [bsa_pkg::ADDR_W-1:0]   slot_address;

   modport source (output valid, output opcode, output slot_address, input ready);
   modport sink (input valid, input opcode, input slot_address, output ready);
endinterface

### hw/rtl/bsa_rsp_if.sv
// bsa_rsp_if: response channel, valid/ready with granted address and status
// depends on bsa_pkg
interface bsa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bsa_pkg::ADDR_W-1:0]   granted_address;
   logic [bsa_pkg::STAT_W-1:0]   status;

   modport source (output valid, output granted_address, output status, input ready);
   modport sink (input valid, input granted_address, input status, output ready);
endinterface

### hw/rtl/bsa_ram.sv
// bsa_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module bsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/bsa_ctrl.sv
// bsa_ctrl: sequencer for allocate and free, drives datapath commands
// depends on bsa_pkg
module bsa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bsa_pkg::dp_sts_type sts,
   output bsa_pkg::dp_cmd_type cmd
);
   bsa_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic can_emit;

   assign can_emit = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsa_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsa_pkg::S_IDLE: begin
            if (req_valid) state_in = bsa_pkg::S_DISPATCH;
         end
         bsa_pkg::S_DISPATCH: begin
            if (sts.is_free) state_in = sts.free_bad ? bsa_pkg::S_OUT : bsa_pkg::S_FIND_RD;
            else state_in = sts.total_zero ? bsa_pkg::S_OUT : bsa_pkg::S_SEARCH;
         end
         bsa_pkg::S_SEARCH: begin
            if (sts.has_free) state_in = sts.end_zero ? bsa_pkg::S_OUT : bsa_pkg::S_TAKE;
            else if (sts.blk_zero) state_in = bsa_pkg::S_OUT;
         end
         bsa_pkg::S_TAKE: state_in = bsa_pkg::S_TRIM_RD;
         bsa_pkg::S_TRIM_RD: begin
            state_in = sts.end_zero ? bsa_pkg::S_OUT : bsa_pkg::S_TRIM_CK;
         end
         bsa_pkg::S_TRIM_CK: begin
            state_in = sts.rd_zero ? bsa_pkg::S_TRIM_RD : bsa_pkg::S_OUT;
         end
         bsa_pkg::S_FIND_RD: begin
            if (!sts.scan_done) state_in = bsa_pkg::S_FIND_CK;
            else if (sts.is_top) state_in = sts.slot_zero ? bsa_pkg::S_OUT : bsa_pkg::S_PURGE_RD;
            else state_in = sts.end_full ? bsa_pkg::S_CMP_RD : bsa_pkg::S_APPEND;
         end
         bsa_pkg::S_FIND_CK: begin
            state_in = sts.hit ? bsa_pkg::S_OUT : bsa_pkg::S_FIND_RD;
         end
         bsa_pkg::S_PURGE_RD: begin
            state_in = sts.scan_done ? bsa_pkg::S_TRIM_RD : bsa_pkg::S_PURGE_CK;
         end
         bsa_pkg::S_PURGE_CK: begin
            state_in = (sts.hit && sts.slot_zero) ? bsa_pkg::S_TRIM_RD : bsa_pkg::S_PURGE_RD;
         end
         bsa_pkg::S_CMP_RD: begin
            state_in = sts.scan_done ? bsa_pkg::S_APPEND : bsa_pkg::S_CMP_CK;
         end
         bsa_pkg::S_CMP_CK: state_in = bsa_pkg::S_CMP_RD;
         bsa_pkg::S_APPEND: state_in = bsa_pkg::S_OUT;
         bsa_pkg::S_OUT: begin
            if (can_emit) state_in = bsa_pkg::S_IDLE;
         end
         default: state_in = bsa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op       = bsa_pkg::OP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         bsa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = bsa_pkg::OP_LOAD;
         end
         bsa_pkg::S_DISPATCH: begin
            if (sts.is_free) begin
               cmd.op = sts.free_bad ? bsa_pkg::OP_IGNORE : bsa_pkg::OP_SCAN_INIT;
            end else if (sts.total_zero) begin
               cmd.op = sts.active_full ? bsa_pkg::OP_OOM : bsa_pkg::OP_ACTIVATE;
            end
         end
         bsa_pkg::S_SEARCH: begin
            if (sts.has_free) cmd.op = sts.end_zero ? bsa_pkg::OP_BUMP : bsa_pkg::OP_RD_LAST;
            else cmd.op = sts.blk_zero ? bsa_pkg::OP_OOM : bsa_pkg::OP_BLK_DEC;
         end
         bsa_pkg::S_TAKE: cmd.op = bsa_pkg::OP_TAKE;
         bsa_pkg::S_TRIM_RD: begin
            if (!sts.end_zero) cmd.op = bsa_pkg::OP_RD_LAST;
         end
         bsa_pkg::S_TRIM_CK: begin
            if (sts.rd_zero) cmd.op = bsa_pkg::OP_END_DEC;
         end
         bsa_pkg::S_FIND_RD: begin
            if (!sts.scan_done) cmd.op = bsa_pkg::OP_RD_IDX;
            else if (sts.is_top) begin
               cmd.op = sts.slot_zero ? bsa_pkg::OP_TOP0 : bsa_pkg::OP_PURGE_INIT;
            end else if (sts.end_full) cmd.op = bsa_pkg::OP_CMP_INIT;
         end
         bsa_pkg::S_FIND_CK: begin
            cmd.op = sts.hit ? bsa_pkg::OP_IGNORE : bsa_pkg::OP_IDX_INC;
         end
         bsa_pkg::S_PURGE_RD: begin
            cmd.op = sts.scan_done ? bsa_pkg::OP_PURGE_END : bsa_pkg::OP_RD_IDX;
         end
         bsa_pkg::S_PURGE_CK: begin
            if (!sts.hit) cmd.op = bsa_pkg::OP_IDX_INC;
            else cmd.op = sts.slot_zero ? bsa_pkg::OP_PURGE_LAST : bsa_pkg::OP_PURGE_HIT;
         end
         bsa_pkg::S_CMP_RD: begin
            cmd.op = sts.scan_done ? bsa_pkg::OP_CMP_END : bsa_pkg::OP_RD_IDX;
         end
         bsa_pkg::S_CMP_CK: cmd.op = bsa_pkg::OP_CMP_STEP;
         bsa_pkg::S_APPEND: cmd.op = bsa_pkg::OP_APPEND;
         bsa_pkg::S_OUT: begin
            if (can_emit) begin
               cmd.op       = bsa_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd.op = bsa_pkg::OP_NONE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

### hw/rtl/bsa_dp.sv
// bsa_dp: block bookkeeping registers, hole list ram and result registers
// depends on bsa_pkg and bsa_ram
module bsa_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bsa_pkg::dp_cmd_type           cmd,
   output bsa_pkg::dp_sts_type           sts,
   input  logic                          req_opcode,
   input  logic [bsa_pkg::ADDR_W-1:0]    req_slot_address,
   input  logic                          csr_wr_en,
   input  logic [bsa_pkg::EPB_W-1:0]     csr_wr_data,
   output logic [bsa_pkg::ADDR_W-1:0]    rsp_granted_address,
   output logic [bsa_pkg::STAT_W-1:0]    rsp_status
);
   localparam int NB = bsa_pkg::MAX_BLOCKS;

   logic [bsa_pkg::EPB_W-1:0]  epb_ff, epb_in;
   logic [bsa_pkg::ACT_W-1:0]  active_ff, active_in;
   logic [bsa_pkg::TOT_W-1:0]  total_ff, total_in;
   logic [bsa_pkg::CNT_W-1:0]  fcnt_ff [NB];
   logic [bsa_pkg::CNT_W-1:0]  fcnt_in [NB];
   logic [bsa_pkg::SLOT_W-1:0] top_ff [NB];
   logic [bsa_pkg::SLOT_W-1:0] top_in [NB];
   logic [bsa_pkg::CNT_W-1:0]  end_ff [NB];
   logic [bsa_pkg::CNT_W-1:0]  end_in [NB];
   logic                       opc_ff, opc_in;
   logic [bsa_pkg::BLK_W-1:0]  blk_ff, blk_in;
   logic [bsa_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [bsa_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [bsa_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [bsa_pkg::ADDR_W-1:0] grant_ff, grant_in;
   logic [bsa_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic [bsa_pkg::ADDR_W-1:0] out_grant_ff, out_grant_in;
   logic [bsa_pkg::STAT_W-1:0] out_stat_ff, out_stat_in;

   logic [bsa_pkg::CNT_W-1:0]  cur_fcnt, cur_end, end_m1, bump, epb_w;
   logic [bsa_pkg::SLOT_W-1:0] cur_top;
   logic [bsa_pkg::BLK_W-1:0]  new_blk;
   logic [bsa_pkg::HOLE_W-1:0] rdata, take, slot_key;
   logic                       wr_en;
   logic [bsa_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [bsa_pkg::HOLE_W-1:0] wr_data;
   logic [bsa_pkg::EPB_W-1:0]  epb_clamped;

   bsa_ram #(.WIDTH(bsa_pkg::HOLE_W), .DEPTH(bsa_pkg::RAM_DEPTH)) u_hole_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rdata)
   );

   assign cur_fcnt = fcnt_ff[blk_ff];
   assign cur_top  = top_ff[blk_ff];
   assign cur_end  = end_ff[blk_ff];
   assign end_m1   = cur_end - bsa_pkg::CNT_W'(1);
   assign epb_w    = bsa_pkg::CNT_W'(epb_ff);
   assign bump     = epb_w - cur_fcnt;
   assign take     = rdata - bsa_pkg::HOLE_W'(1);
   assign slot_key = {1'b0, slot_ff} + bsa_pkg::HOLE_W'(1);
   assign new_blk  = active_ff[bsa_pkg::BLK_W-1:0];

   always_comb begin
      if (csr_wr_data == '0) epb_clamped = bsa_pkg::EPB_W'(1);
      else if (csr_wr_data > bsa_pkg::EPB_W'(bsa_pkg::SLOTS_PER_BLOCK))
         epb_clamped = bsa_pkg::EPB_W'(bsa_pkg::SLOTS_PER_BLOCK);
      else epb_clamped = csr_wr_data;
   end

   always_comb begin
      sts.is_free     = opc_ff;
      sts.total_zero  = total_ff == '0;
      sts.active_full = active_ff == bsa_pkg::ACT_W'(bsa_pkg::MAX_BLOCKS);
      sts.has_free    = cur_fcnt != '0;
      sts.blk_zero    = blk_ff == '0;
      sts.end_zero    = cur_end == '0;
      sts.end_full    = cur_end >= bsa_pkg::CNT_W'(bsa_pkg::SLOTS_PER_BLOCK);
      sts.scan_done   = idx_ff == cur_end;
      sts.free_bad    = ({1'b0, blk_ff} >= active_ff) ||
                        ({1'b0, slot_ff} >= epb_w) ||
                        (cur_fcnt >= epb_w) || (slot_ff > cur_top);
      sts.is_top      = slot_ff == cur_top;
      sts.slot_zero   = slot_ff == '0;
      sts.hit         = rdata == slot_key;
      sts.rd_zero     = rdata == '0;
   end

   always_comb begin
      epb_in       = epb_ff;
      active_in    = active_ff;
      total_in     = total_ff;
      fcnt_in      = fcnt_ff;
      top_in       = top_ff;
      end_in       = end_ff;
      opc_in       = opc_ff;
      blk_in       = blk_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      grant_in     = grant_ff;
      stat_in      = stat_ff;
      out_grant_in = out_grant_ff;
      out_stat_in  = out_stat_ff;
      wr_en        = 1'b0;
      wr_addr      = {blk_ff, end_m1[bsa_pkg::SLOT_W-1:0]};
      wr_data      = '0;
      rd_addr      = {blk_ff, end_m1[bsa_pkg::SLOT_W-1:0]};

      // the block size is frozen once any block is active
      if (csr_wr_en && active_ff == '0) epb_in = epb_clamped;

      case (cmd.op)
         bsa_pkg::OP_LOAD: begin
            opc_in   = req_opcode;
            grant_in = '0;
            if (req_opcode == bsa_pkg::OPC_FREE) begin
               blk_in  = req_slot_address[bsa_pkg::ADDR_W-1:bsa_pkg::SLOT_W];
               slot_in = req_slot_address[bsa_pkg::SLOT_W-1:0];
               stat_in = bsa_pkg::STAT_FREED;
            end else begin
               // search starts at the newest block
               blk_in  = new_blk - bsa_pkg::BLK_W'(1);
               stat_in = bsa_pkg::STAT_ALLOC;
            end
         end
         bsa_pkg::OP_OOM: stat_in = bsa_pkg::STAT_OOM;
         bsa_pkg::OP_IGNORE: stat_in = bsa_pkg::STAT_IGNORED;
         bsa_pkg::OP_ACTIVATE: begin
            fcnt_in[new_blk] = epb_w - bsa_pkg::CNT_W'(1);
            top_in[new_blk]  = '0;
            end_in[new_blk]  = '0;
            active_in        = active_ff + bsa_pkg::ACT_W'(1);
            total_in         = total_ff + bsa_pkg::TOT_W'(epb_w - bsa_pkg::CNT_W'(1));
            grant_in         = {new_blk, {bsa_pkg::SLOT_W{1'b0}}};
         end
         bsa_pkg::OP_BLK_DEC: blk_in = blk_ff - bsa_pkg::BLK_W'(1);
         bsa_pkg::OP_BUMP: begin
            top_in[blk_ff]  = bump[bsa_pkg::SLOT_W-1:0];
            fcnt_in[blk_ff] = cur_fcnt - bsa_pkg::CNT_W'(1);
            total_in        = total_ff - bsa_pkg::TOT_W'(1);
            grant_in        = {blk_ff, bump[bsa_pkg::SLOT_W-1:0]};
         end
         bsa_pkg::OP_TAKE: begin
            wr_en           = 1'b1;
            end_in[blk_ff]  = end_m1;
            fcnt_in[blk_ff] = cur_fcnt - bsa_pkg::CNT_W'(1);
            total_in        = total_ff - bsa_pkg::TOT_W'(1);
            grant_in        = {blk_ff, take[bsa_pkg::SLOT_W-1:0]};
         end
         bsa_pkg::OP_END_DEC: end_in[blk_ff] = end_m1;
         bsa_pkg::OP_SCAN_INIT: idx_in = '0;
         bsa_pkg::OP_RD_IDX: rd_addr = {blk_ff, idx_ff[bsa_pkg::SLOT_W-1:0]};
         bsa_pkg::OP_IDX_INC: idx_in = idx_ff + bsa_pkg::CNT_W'(1);
         bsa_pkg::OP_TOP0: begin
            end_in[blk_ff]  = '0;
            fcnt_in[blk_ff] = cur_fcnt + bsa_pkg::CNT_W'(1);
            total_in        = total_ff + bsa_pkg::TOT_W'(1);
         end
         bsa_pkg::OP_PURGE_INIT: begin
            slot_in = slot_ff - bsa_pkg::SLOT_W'(1);
            idx_in  = '0;
         end
         bsa_pkg::OP_PURGE_HIT: begin
            wr_en   = 1'b1;
            wr_addr = {blk_ff, idx_ff[bsa_pkg::SLOT_W-1:0]};
            slot_in = slot_ff - bsa_pkg::SLOT_W'(1);
            idx_in  = '0;
         end
         bsa_pkg::OP_PURGE_LAST: begin
            // purge reached slot 0: block is empty
            wr_en           = 1'b1;
            wr_addr         = {blk_ff, idx_ff[bsa_pkg::SLOT_W-1:0]};
            top_in[blk_ff]  = '0;
            fcnt_in[blk_ff] = cur_fcnt + bsa_pkg::CNT_W'(1);
            total_in        = total_ff + bsa_pkg::TOT_W'(1);
         end
         bsa_pkg::OP_PURGE_END: begin
            top_in[blk_ff]  = slot_ff;
            fcnt_in[blk_ff] = cur_fcnt + bsa_pkg::CNT_W'(1);
            total_in        = total_ff + bsa_pkg::TOT_W'(1);
         end
         bsa_pkg::OP_CMP_INIT: begin
            idx_in = '0;
            cnt_in = '0;
         end
         bsa_pkg::OP_CMP_STEP: begin
            if (rdata != '0) begin
               wr_en   = 1'b1;
               wr_addr = {blk_ff, cnt_ff[bsa_pkg::SLOT_W-1:0]};
               wr_data = rdata;
               cnt_in  = cnt_ff + bsa_pkg::CNT_W'(1);
            end
            idx_in = idx_ff + bsa_pkg::CNT_W'(1);
         end
         bsa_pkg::OP_CMP_END: end_in[blk_ff] = cnt_ff;
         bsa_pkg::OP_APPEND: begin
            if (!sts.end_full) begin
               wr_en          = 1'b1;
               wr_addr        = {blk_ff, cur_end[bsa_pkg::SLOT_W-1:0]};
               wr_data        = slot_key;
               end_in[blk_ff] = cur_end + bsa_pkg::CNT_W'(1);
            end
            fcnt_in[blk_ff] = cur_fcnt + bsa_pkg::CNT_W'(1);
            total_in        = total_ff + bsa_pkg::TOT_W'(1);
         end
         bsa_pkg::OP_EMIT: begin
            out_grant_in = grant_ff;
            out_stat_in  = stat_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epb_ff    <= bsa_pkg::EPB_W'(bsa_pkg::SLOTS_PER_BLOCK);
         active_ff <= '0;
         total_ff  <= '0;
      end else begin
         epb_ff    <= epb_in;
         active_ff <= active_in;
         total_ff  <= total_in;
      end
      fcnt_ff      <= fcnt_in;
      top_ff       <= top_in;
      end_ff       <= end_in;
      opc_ff       <= opc_in;
      blk_ff       <= blk_in;
      slot_ff      <= slot_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      grant_ff     <= grant_in;
      stat_ff      <= stat_in;
      out_grant_ff <= out_grant_in;
      out_stat_ff  <= out_stat_in;
   end

   assign rsp_granted_address = out_grant_ff;
   assign rsp_status          = out_stat_ff;
endmodule

### hw/rtl/block_slot_allocator.sv
// block_slot_allocator: slot allocator over up to 8 blocks of 64 slots with hole lists
// each hole list entry visited takes a registered ram read, then a compare; the worst case
// is a free with a long purge; one item at a time, next item accepted once the result is
// in the output register; reset: synchronous active high, no blocks, size 64
module block_slot_allocator (
   input  logic                       clock,
   input  logic                       reset,
   bsa_req_if.sink                    req_ch,
   bsa_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [bsa_pkg::EPB_W-1:0]  csr_wr_data
);
   bsa_pkg::dp_cmd_type cmd;
   bsa_pkg::dp_sts_type sts;

   bsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bsa_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_opcode          (req_ch.opcode),
      .req_slot_address    (req_ch.slot_address),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_granted_address (rsp_ch.granted_address),
      .rsp_status          (rsp_ch.status)
   );

   // only allocations carry an address
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != bsa_pkg::STAT_ALLOC |-> rsp_ch.granted_address == '0)
      else $error("nonzero address on a result that is not an allocation");

   // one item in service at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while another item is in service");
endmodule

### tb/sv/tb_block_slot_allocator.sv
`timescale 1ns / 100ps
// tb_block_slot_allocator: self-checking bench for the block slot allocator
// depends on bsa_pkg, bsa_req_if, bsa_rsp_if and block_slot_allocator
module tb_block_slot_allocator;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int SPB = bsa_pkg::SLOTS_PER_BLOCK;

   typedef struct packed {
      logic [bsa_pkg::ADDR_W-1:0] addr;
      logic [bsa_pkg::STAT_W-1:0] status;
   } grant_type;

   typedef struct packed {
      logic                       opcode;
      logic [bsa_pkg::ADDR_W-1:0] addr;
      logic                       known;
      logic [bsa_pkg::ADDR_W-1:0] exp_addr;
      logic [bsa_pkg::STAT_W-1:0] exp_status;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [bsa_pkg::EPB_W-1:0] csr_wr_data = '0;

   bsa_req_if req_ch ();
   bsa_rsp_if rsp_ch ();

   block_slot_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // allocator shadow state
   int slots_used;
   int blocks_live;
   int free_total;
   int blk_free [bsa_pkg::MAX_BLOCKS];
   int blk_top [bsa_pkg::MAX_BLOCKS];
   int hole_end [bsa_pkg::MAX_BLOCKS];
   int holes [bsa_pkg::RAM_DEPTH];

   grant_type grant_q [$];
   logic [bsa_pkg::ADDR_W-1:0] live_q [$];
   int mismatches = 0;
   int n_alloc = 0, n_freed = 0, n_oom = 0, n_ignored = 0;
   int idle_cycles = 0;
   bit rsp_hold = 1'b0;
   bit rsp_nogap = 1'b0;

   function automatic int hole_index(int b, int s);
      for (int i = 0; i < hole_end[b]; i++)
         if (holes[b*SPB + i] == s + 1) return i;
      return -1;
   endfunction

   function automatic void trim(int b);
      while (hole_end[b] >= 1 && holes[b*SPB + hole_end[b] - 1] == 0)
         hole_end[b]--;
   endfunction

   function automatic grant_type take_slot();
      grant_type r;
      int slot;
      bit got;
      int last;
      r.addr = '0;
      r.status = bsa_pkg::STAT_OOM;
      if (free_total == 0) begin
         if (blocks_live >= bsa_pkg::MAX_BLOCKS) return r;
         blk_free[blocks_live] = slots_used - 1;
         blk_top[blocks_live] = 0;
         hole_end[blocks_live] = 0;
         for (int i = 0; i < SPB; i++)
            holes[blocks_live*SPB + i] = 0;
         r.addr = bsa_pkg::ADDR_W'(blocks_live * SPB);
         r.status = bsa_pkg::STAT_ALLOC;
         blocks_live++;
         free_total += slots_used - 1;
         return r;
      end
      for (int b = blocks_live - 1; b >= 0; b--) begin
         if (blk_free[b] == 0) continue;
         got = 1'b0;
         slot = 0;
         if (hole_end[b] != 0) begin
            last = b*SPB + hole_end[b] - 1;
            if (holes[last] != 0) begin
               slot = holes[last] - 1;
               holes[last] = 0;
               got = 1'b1;
            end else begin
               for (int i = 0; i < hole_end[b]; i++)
                  if (!got && holes[b*SPB + i] != 0) begin
                     slot = holes[b*SPB + i] - 1;
                     holes[b*SPB + i] = 0;
                     got = 1'b1;
                  end
            end
            trim(b);
         end
         if (!got) begin
            slot = slots_used - blk_free[b];
            blk_top[b] = slot;
         end
         blk_free[b]--;
         free_total--;
         r.addr = bsa_pkg::ADDR_W'(b*SPB + slot);
         r.status = bsa_pkg::STAT_ALLOC;
         return r;
      end
      return r;
   endfunction

   function automatic logic [bsa_pkg::STAT_W-1:0] release_slot(
         logic [bsa_pkg::ADDR_W-1:0] addr);
      int b, s, t, i, n;
      b = int'(addr) / SPB;
      s = int'(addr) % SPB;
      if (b >= blocks_live || s >= slots_used || blk_free[b] >= slots_used ||
          s > blk_top[b] || hole_index(b, s) >= 0)
         return bsa_pkg::STAT_IGNORED;
      if (s == blk_top[b]) begin
         if (s == 0) begin
            hole_end[b] = 0;
         end else begin
            t = s - 1;
            i = hole_index(b, t);
            while (i >= 0) begin
               holes[b*SPB + i] = 0;
               if (t == 0) break;
               t--;
               i = hole_index(b, t);
            end
            blk_top[b] = t;
            trim(b);
         end
      end else begin
         if (hole_end[b] >= SPB) begin
            // squeeze out empty entries before appending
            n = 0;
            for (int k = 0; k < hole_end[b]; k++)
               if (holes[b*SPB + k] != 0) begin
                  holes[b*SPB + n] = holes[b*SPB + k];
                  n++;
               end
            for (int k = n; k < SPB; k++) holes[b*SPB + k] = 0;
            hole_end[b] = n;
         end
         if (hole_end[b] < SPB) begin
            holes[b*SPB + hole_end[b]] = s + 1;
            hole_end[b]++;
         end
      end
      blk_free[b]++;
      free_total++;
      return bsa_pkg::STAT_FREED;
   endfunction

   function automatic grant_type predict_grant(logic opcode,
                                               logic [bsa_pkg::ADDR_W-1:0] addr);
      grant_type r;
      if (opcode == bsa_pkg::OPC_ALLOC) begin
         r = take_slot();
      end else begin
         r.addr = '0;
         r.status = release_slot(addr);
      end
      case (r.status)
         bsa_pkg::STAT_ALLOC: begin
            n_alloc++;
            live_q.push_back(r.addr);
         end
         bsa_pkg::STAT_FREED: begin
            n_freed++;
            foreach (live_q[k])
               if (live_q[k] == addr) begin
                  live_q.delete(k);
                  break;
               end
         end
         bsa_pkg::STAT_OOM: n_oom++;
         default: n_ignored++;
      endcase
      return r;
   endfunction

   function automatic void shadow_reset();
      slots_used = SPB;
      blocks_live = 0;
      free_total = 0;
      for (int b = 0; b < bsa_pkg::MAX_BLOCKS; b++) begin
         blk_free[b] = 0;
         blk_top[b] = 0;
         hole_end[b] = 0;
      end
      for (int i = 0; i < bsa_pkg::RAM_DEPTH; i++) holes[i] = 0;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      forever #4 clock = ~clock;
   end

   // result side: random stalls (none in phase 3), one long hold-off on request
   always @(posedge clock) begin
      if (reset || rsp_hold)
         rsp_ch.ready <= 1'b0;
      else if (rsp_nogap)
         rsp_ch.ready <= 1'b1;
      else
         rsp_ch.ready <= ($urandom_range(0, 9) < 7);
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (grant_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: addr %0d status %0d",
                        rsp_ch.granted_address, rsp_ch.status);
         end else begin
            want = grant_q.pop_front();
            if (want.addr !== rsp_ch.granted_address || want.status !== rsp_ch.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                           want.addr, want.status, rsp_ch.granted_address, rsp_ch.status);
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", grant_q.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_item(logic opcode, logic [bsa_pkg::ADDR_W-1:0] addr, int gap,
                            bit known = 1'b0, grant_type typed = '0);
      grant_type r;
      req_ch.valid <= 1'b1;
      req_ch.opcode <= opcode;
      req_ch.slot_address <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      r = predict_grant(opcode, addr);
      grant_q.push_back(known ? typed : r);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(logic [bsa_pkg::EPB_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // the size is frozen once any block is live
      if (blocks_live == 0) begin
         if (value == '0) slots_used = 1;
         else if (int'(value) > SPB) slots_used = SPB;
         else slots_used = int'(value);
      end
   endtask

   initial begin
      dir_row_type rows [23];
      int alloc_pct;
      logic op;
      logic [bsa_pkg::ADDR_W-1:0] addr;

      // block size 4 for the directed rows
      rows = '{
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b1, 9'd0,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_FREE,  9'd0,   1'b1, 9'd0,  bsa_pkg::STAT_FREED},
         '{bsa_pkg::OPC_FREE,  9'd0,   1'b1, 9'd0,  bsa_pkg::STAT_IGNORED},
         '{bsa_pkg::OPC_FREE,  9'd511, 1'b1, 9'd0,  bsa_pkg::STAT_IGNORED},
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b1, 9'd0,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b1, 9'd1,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b1, 9'd2,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b1, 9'd3,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_ALLOC, 9'd511, 1'b1, 9'd64, bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_FREE,  9'd1,   1'b1, 9'd0,  bsa_pkg::STAT_FREED},
         '{bsa_pkg::OPC_FREE,  9'd2,   1'b1, 9'd0,  bsa_pkg::STAT_FREED},
         '{bsa_pkg::OPC_FREE,  9'd1,   1'b1, 9'd0,  bsa_pkg::STAT_IGNORED},
         '{bsa_pkg::OPC_FREE,  9'd3,   1'b1, 9'd0,  bsa_pkg::STAT_FREED},
         '{bsa_pkg::OPC_FREE,  9'd0,   1'b1, 9'd0,  bsa_pkg::STAT_FREED},
         '{bsa_pkg::OPC_FREE,  9'd70,  1'b1, 9'd0,  bsa_pkg::STAT_IGNORED},
         '{bsa_pkg::OPC_FREE,  9'd66,  1'b1, 9'd0,  bsa_pkg::STAT_IGNORED},
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b0, 9'd0,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_FREE,  9'd64,  1'b0, 9'd0,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b0, 9'd0,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b0, 9'd0,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_FREE,  9'd65,  1'b0, 9'd0,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_FREE,  9'd66,  1'b0, 9'd0,  bsa_pkg::STAT_ALLOC},
         '{bsa_pkg::OPC_ALLOC, 9'd0,   1'b0, 9'd0,  bsa_pkg::STAT_ALLOC}
      };

      req_ch.valid <= 1'b0;
      req_ch.opcode <= bsa_pkg::OPC_ALLOC;
      req_ch.slot_address <= '0;
      shadow_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // out-of-range sizes clamp; the last write before the first allocate sticks
      write_size(7'd127);
      write_size(7'd0);
      write_size(7'd4);

      foreach (rows[i])
         send_item(rows[i].opcode, rows[i].addr, pick_gap(), rows[i].known,
                   grant_type'({rows[i].exp_addr, rows[i].exp_status}));

      for (int phase = 0; phase < 5; phase++) begin
         // ignored once blocks are live, still exercised at both extremes
         write_size(phase[0] ? 7'd64 : 7'd1);
         alloc_pct = (phase == 0) ? 80 : (phase == 1) ? 20 : (phase == 2) ? 55 :
                     (phase == 3) ? 70 : 35;
         rsp_nogap = (phase == 3);
         if (phase == 2) begin
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (400) @(posedge clock);
                  rsp_hold = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(1, 100) <= alloc_pct) begin
               op = bsa_pkg::OPC_ALLOC;
               addr = bsa_pkg::ADDR_W'($urandom_range(0, 511));
            end else begin
               op = bsa_pkg::OPC_FREE;
               if (live_q.size() != 0 && $urandom_range(0, 9) < 8)
                  addr = live_q[$urandom_range(0, live_q.size() - 1)];
               else
                  addr = bsa_pkg::ADDR_W'($urandom_range(0, 511));
            end
            send_item(op, addr, (phase == 3) ? 0 : pick_gap());
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d grants, %0d frees, %0d out-of-memory, %0d ignored frees",
               n_alloc, n_freed, n_oom, n_ignored);
      $display("final block size %0d with %0d blocks live, %0d mismatches",
               slots_used, blocks_live, mismatches);
      if (mismatches == 0 && grant_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/bsa_pkg.sv
hw/rtl/bsa_req_if.sv
hw/rtl/bsa_rsp_if.sv
hw/rtl/bsa_ram.sv
hw/rtl/bsa_ctrl.sv
hw/rtl/bsa_dp.sv
hw/rtl/block_slot_allocator.sv
tb/sv/tb_block_slot_allocator.sv
